### hdl/fbc_pkg.sv
// Shared types and constants for the frustum box cull core.
// No dependencies; used by every module under hdl/.
`default_nettype none

package fbc_pkg;

    // Planes the core tests; the model caps this at eight slots.
    localparam int NUM_PLANES  = 6;
    localparam int PLANE_SLOTS = 8;
    localparam int PLANE_COUNT = (NUM_PLANES > PLANE_SLOTS) ? PLANE_SLOTS : NUM_PLANES;

    // Writable plane registers and the width of the register index.
    localparam int PLANE_REGS = 6;
    localparam int CFG_IDX_W  = $clog2(PLANE_REGS);

    localparam int COORD_W = 16;
    localparam int PROD_W  = 2 * COORD_W;
    // three products plus the shifted offset, with headroom
    localparam int SUM_W   = PROD_W + 2;
    localparam int Q_SHIFT = 14;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    // Register layout: d in 63:48, nz 47:32, ny 31:16, nx 15:0.
    typedef struct packed {
        coord_t d;
        coord_t nz;
        coord_t ny;
        coord_t nx;
    } plane_t;

    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } vec3_t;

    // Products of the normal with the positive and negative vertex.
    typedef struct packed {
        prod_t p_x;
        prod_t p_y;
        prod_t p_z;
        prod_t n_x;
        prod_t n_y;
        prod_t n_z;
    } plane_prod_t;

    typedef struct packed {
        logic p_neg;
        logic n_neg;
    } plane_flags_t;

    typedef enum logic [1:0] {
        VERDICT_OUTSIDE   = 2'd0,
        VERDICT_INTERSECT = 2'd1,
        VERDICT_INSIDE    = 2'd2
    } verdict_t;

endpackage

`default_nettype wire

### hdl/fbc_plane_mult.sv
// Per-plane vertex selection and multiply stage of the cull pipeline.
// Depends on fbc_pkg.
`default_nettype none

module fbc_plane_mult (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire fbc_pkg::plane_t    plane,
    input  wire logic               point,
    input  wire fbc_pkg::vec3_t     lo,
    input  wire fbc_pkg::vec3_t     hi,
    output fbc_pkg::plane_prod_t    prod_reg
);

    fbc_pkg::vec3_t       pv;
    fbc_pkg::vec3_t       nv;
    fbc_pkg::plane_prod_t prod_next;

    // Positive vertex: max where the normal is positive. Point mode uses min corner.
    always_comb
    begin
        pv.x = (!point && plane.nx > 0) ? hi.x : lo.x;
        pv.y = (!point && plane.ny > 0) ? hi.y : lo.y;
        pv.z = (!point && plane.nz > 0) ? hi.z : lo.z;
        nv.x = (plane.nx < 0) ? hi.x : lo.x;
        nv.y = (plane.ny < 0) ? hi.y : lo.y;
        nv.z = (plane.nz < 0) ? hi.z : lo.z;
        prod_next.p_x = fbc_pkg::prod_t'(plane.nx) * fbc_pkg::prod_t'(pv.x);
        prod_next.p_y = fbc_pkg::prod_t'(plane.ny) * fbc_pkg::prod_t'(pv.y);
        prod_next.p_z = fbc_pkg::prod_t'(plane.nz) * fbc_pkg::prod_t'(pv.z);
        prod_next.n_x = fbc_pkg::prod_t'(plane.nx) * fbc_pkg::prod_t'(nv.x);
        prod_next.n_y = fbc_pkg::prod_t'(plane.ny) * fbc_pkg::prod_t'(nv.y);
        prod_next.n_z = fbc_pkg::prod_t'(plane.nz) * fbc_pkg::prod_t'(nv.z);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

`default_nettype wire

### hdl/fbc_plane_sum.sv
// Per-plane distance sum and sign stage of the cull pipeline.
// Depends on fbc_pkg.
`default_nettype none

module fbc_plane_sum (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire fbc_pkg::plane_prod_t prod,
    input  wire fbc_pkg::coord_t      d,
    output fbc_pkg::plane_flags_t     flags_reg
);

    fbc_pkg::sum_t         d_term;
    fbc_pkg::sum_t         p_dist;
    fbc_pkg::sum_t         n_dist;
    fbc_pkg::plane_flags_t flags_next;

    always_comb
    begin
        d_term = fbc_pkg::sum_t'(d) <<< fbc_pkg::Q_SHIFT;
        p_dist = fbc_pkg::sum_t'(prod.p_x) + fbc_pkg::sum_t'(prod.p_y)
               + fbc_pkg::sum_t'(prod.p_z) + d_term;
        n_dist = fbc_pkg::sum_t'(prod.n_x) + fbc_pkg::sum_t'(prod.n_y)
               + fbc_pkg::sum_t'(prod.n_z) + d_term;
        flags_next.p_neg = p_dist[fbc_pkg::SUM_W-1];
        flags_next.n_neg = n_dist[fbc_pkg::SUM_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flags_reg <= flags_next;
        end
    end

endmodule

`default_nettype wire

### hdl/frustum_box_cull_core.sv
// Top level of the frustum box cull core: plane registers, pipeline control, verdict.
// Depends on fbc_pkg, fbc_plane_mult and fbc_plane_sum.
//
// Usage:
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes plane
//    registers 0..5 (near, far, top, bottom, left, right); always ready.
//    Indexes past the last plane are taken and dropped. Write only while idle.
//  - Input channel (in_valid/in_ready) takes one box or point per item:
//    func 0 box test, func 1 point test on the min corner.
//  - Output channel (out_valid/out_ready) returns verdict:
//    0 outside, 1 intersecting, 2 inside.
//  - Four register stages: input capture, vertex select and multiply,
//    distance sum and sign, verdict. A result shows on out_valid when the item
//    reaches the verdict stage; one item per clock sustained while out_ready is high.
//  - A stalled output holds the final stage; earlier stages keep filling
//    their empty slots, and in_ready drops only when all four are full.
//  - Reset clears all valid bits and the plane registers; zero planes never
//    cull, so every item reads inside until planes are written.
`default_nettype none

module frustum_box_cull_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [fbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                   cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          func,
    input  wire logic signed [15:0]            min_x,
    input  wire logic signed [15:0]            min_y,
    input  wire logic signed [15:0]            min_z,
    input  wire logic signed [15:0]            max_x,
    input  wire logic signed [15:0]            max_y,
    input  wire logic signed [15:0]            max_z,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         verdict
);

    localparam int NP = fbc_pkg::PLANE_COUNT;

    fbc_pkg::plane_t       plane_reg [NP];
    fbc_pkg::plane_prod_t  prod_s2 [NP];
    fbc_pkg::plane_flags_t flags_s3 [NP];
    logic [NP-1:0]         p_neg_s3;
    logic [NP-1:0]         n_neg_s3;

    logic             v1_reg, v2_reg, v3_reg, v4_reg;
    logic             en1, en2, en3, en4;
    logic             func_s1_reg, func_s2_reg, func_s3_reg;
    fbc_pkg::vec3_t   lo_s1_reg;
    fbc_pkg::vec3_t   hi_s1_reg;
    fbc_pkg::verdict_t verdict_reg;
    fbc_pkg::verdict_t verdict_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NP; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            for (int i = 0; i < NP; i++)
            begin
                if (i < fbc_pkg::PLANE_REGS && cfg_index == fbc_pkg::CFG_IDX_W'(i))
                begin
                    plane_reg[i] <= cfg_data;
                end
            end
        end
    end

    // A stage loads when it is empty or the stage after it moves on.
    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            func_s1_reg <= func;
            lo_s1_reg   <= '{z: min_z, y: min_y, x: min_x};
            hi_s1_reg   <= '{z: max_z, y: max_y, x: max_x};
        end
        if (en2)
        begin
            func_s2_reg <= func_s1_reg;
        end
        if (en3)
        begin
            func_s3_reg <= func_s2_reg;
        end
        if (en4)
        begin
            verdict_reg <= verdict_next;
        end
    end

    for (genvar g = 0; g < NP; g++)
    begin : g_plane
        fbc_plane_mult u_mult (
            .clk      (clk),
            .en       (en2),
            .plane    (plane_reg[g]),
            .point    (func_s1_reg),
            .lo       (lo_s1_reg),
            .hi       (hi_s1_reg),
            .prod_reg (prod_s2[g])
        );

        fbc_plane_sum u_sum (
            .clk       (clk),
            .en        (en3),
            .prod      (prod_s2[g]),
            .d         (plane_reg[g].d),
            .flags_reg (flags_s3[g])
        );

        assign p_neg_s3[g] = flags_s3[g].p_neg;
        assign n_neg_s3[g] = flags_s3[g].n_neg;
    end

    // Any positive vertex behind a plane culls; a negative vertex behind only straddles, and only for boxes.
    always_comb
    begin
        if (|p_neg_s3)
        begin
            verdict_next = fbc_pkg::VERDICT_OUTSIDE;
        end
        else if (!func_s3_reg && |n_neg_s3)
        begin
            verdict_next = fbc_pkg::VERDICT_INTERSECT;
        end
        else
        begin
            verdict_next = fbc_pkg::VERDICT_INSIDE;
        end
    end

    assign out_valid = v4_reg;
    assign verdict   = verdict_reg;

    a_point_never_straddles: assert property (@(posedge clk) disable iff (!rst_n)
        en4 && v3_reg && func_s3_reg |=> verdict != fbc_pkg::VERDICT_INTERSECT)
        else $error("point item produced an intersecting verdict");

    a_cull_wins: assert property (@(posedge clk) disable iff (!rst_n)
        en4 && v3_reg && (|p_neg_s3) |=> out_valid && verdict == fbc_pkg::VERDICT_OUTSIDE)
        else $error("positive vertex behind a plane did not give outside");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        en4 && v3_reg |=> out_valid)
        else $error("item lost between sum stage and output");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && v2_reg && v3_reg && v4_reg && !out_ready |-> !in_ready)
        else $error("input taken while pipeline full and stalled");

endmodule

`default_nettype wire

### sim/frustum_box_cull_core_tb.sv
// Self-checking bench for frustum_box_cull_core: directed and random boxes and points
// against several plane sets, with a verdict predictor kept inside the bench.
// Depends on fbc_pkg and the core under hdl/.
`timescale 1ns / 1ps

module frustum_box_cull_core_tb;
    import fbc_pkg::*;

    localparam int RAND_PHASES    = 6;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int DRAIN_CYCLES   = 8;
    localparam int STALL_LIMIT    = 1000;

    typedef struct packed {
        logic   func;
        coord_t min_x;
        coord_t min_y;
        coord_t min_z;
        coord_t max_x;
        coord_t max_y;
        coord_t max_z;
    } box_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    box_item_t            box_on_bus = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [1:0]           verdict;

    // bench copy of the plane registers; slots past the writable ones stay zero
    plane_t frustum[PLANE_SLOTS] = '{default: '0};

    box_item_t            box_backlog[$];
    verdict_t             want_verdicts[$];
    logic [CFG_IDX_W-1:0] reg_idx_q[$];
    logic [63:0]          reg_val_q[$];

    logic     idle_en = 1'b1;
    int       gap_left = 0;
    int       stall_left = 0;
    int       n_errors = 0;
    int       n_checked = 0;
    int       n_points = 0;
    int       n_reg_writes = 0;
    int       n_by_verdict[3] = '{0, 0, 0};
    int       quiet_cycles = 0;
    verdict_t w_exp;

    frustum_box_cull_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (box_on_bus.func),
        .min_x     (box_on_bus.min_x),
        .min_y     (box_on_bus.min_y),
        .min_z     (box_on_bus.min_z),
        .max_x     (box_on_bus.max_x),
        .max_y     (box_on_bus.max_y),
        .max_z     (box_on_bus.max_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .verdict   (verdict)
    );

    always #4 clk = ~clk;

    // signed distance scaled by 2^14: n . v + d << 14
    function automatic longint plane_dist(plane_t p, longint x, longint y, longint z);
        return longint'($signed(p.nx)) * x + longint'($signed(p.ny)) * y
            + longint'($signed(p.nz)) * z + (longint'($signed(p.d)) <<< Q_SHIFT);
    endfunction

    function automatic verdict_t cull_verdict(box_item_t b);
        longint   lo[3];
        longint   hi[3];
        longint   pv[3];
        longint   nv[3];
        longint   n[3];
        plane_t   p;
        verdict_t v;
        v = VERDICT_INSIDE;
        lo[0] = b.min_x;
        lo[1] = b.min_y;
        lo[2] = b.min_z;
        hi[0] = b.max_x;
        hi[1] = b.max_y;
        hi[2] = b.max_z;
        for (int i = 0; i < PLANE_COUNT; i++)
        begin
            p = frustum[i];
            n[0] = $signed(p.nx);
            n[1] = $signed(p.ny);
            n[2] = $signed(p.nz);
            if (b.func)
            begin
                if (plane_dist(p, lo[0], lo[1], lo[2]) < 0)
                    return VERDICT_OUTSIDE;
            end
            else
            begin
                // no reordering of inverted bounds: pick straight from min/max
                for (int a = 0; a < 3; a++)
                begin
                    pv[a] = (n[a] > 0) ? hi[a] : lo[a];
                    nv[a] = (n[a] < 0) ? hi[a] : lo[a];
                end
                if (plane_dist(p, pv[0], pv[1], pv[2]) < 0)
                    return VERDICT_OUTSIDE;
                if (plane_dist(p, nv[0], nv[1], nv[2]) < 0)
                    v = VERDICT_INTERSECT;
            end
        end
        return v;
    endfunction

    function automatic box_item_t box_of(logic f, int x0, int y0, int z0,
                                         int x1, int y1, int z1);
        box_item_t b;
        b.func  = f;
        b.min_x = coord_t'(x0);
        b.min_y = coord_t'(y0);
        b.min_z = coord_t'(z0);
        b.max_x = coord_t'(x1);
        b.max_y = coord_t'(y1);
        b.max_z = coord_t'(z1);
        return b;
    endfunction

    // mostly boxes around the origin so all three verdicts show up;
    // some full-range noise and some inverted boxes
    function automatic box_item_t random_box();
        int lo[3];
        int hi[3];
        int c;
        int h;
        int t;
        for (int a = 0; a < 3; a++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                lo[a] = int'($urandom_range(0, 65535)) - 32768;
                hi[a] = int'($urandom_range(0, 65535)) - 32768;
            end
            else
            begin
                c = int'($urandom_range(0, 12000)) - 6000;
                h = $urandom_range(0, 3000);
                lo[a] = c - h;
                hi[a] = c + h;
                if ($urandom_range(0, 15) == 0)
                begin
                    t = lo[a];
                    lo[a] = hi[a];
                    hi[a] = t;
                end
            end
        end
        return box_of($urandom_range(0, 3) == 0, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endfunction

    // plane facing roughly inward, with the origin on its inner side
    function automatic plane_t sane_plane();
        plane_t p;
        p.nx = ($urandom_range(0, 7) == 0) ? '0 : coord_t'(int'($urandom_range(0, 32768)) - 16384);
        p.ny = ($urandom_range(0, 7) == 0) ? '0 : coord_t'(int'($urandom_range(0, 32768)) - 16384);
        p.nz = ($urandom_range(0, 7) == 0) ? '0 : coord_t'(int'($urandom_range(0, 32768)) - 16384);
        p.d  = coord_t'($urandom_range(200, 6000));
        return p;
    endfunction

    // item driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                want_verdicts.push_back(cull_verdict(box_on_bus));
                if (box_on_bus.func)
                    n_points <= n_points + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (box_backlog.size() != 0)
                begin
                    if (idle_en && $urandom_range(0, 9) == 0)
                    begin
                        in_valid <= 1'b0;
                        gap_left <= $urandom_range(0, 15);
                    end
                    else
                    begin
                        box_on_bus <= box_backlog.pop_front();
                        in_valid <= 1'b1;
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // verdict monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (want_verdicts.size() == 0)
                begin
                    $display("%t: verdict %0d arrived with none pending", $time, verdict);
                    n_errors <= n_errors + 1;
                end
                else
                begin
                    w_exp = want_verdicts.pop_front();
                    if (verdict !== w_exp)
                    begin
                        $display("%t: verdict mismatch, expected %0d, actual %0d",
                                 $time, w_exp, verdict);
                        n_errors <= n_errors + 1;
                    end
                    if (w_exp <= VERDICT_INSIDE)
                        n_by_verdict[w_exp] <= n_by_verdict[w_exp] + 1;
                    n_checked <= n_checked + 1;
                end
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (idle_en && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                stall_left <= $urandom_range(0, 15);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog on lack of progress
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%t: no handshake for %0d cycles, %0d verdicts outstanding",
                     $time, STALL_LIMIT, want_verdicts.size());
            $display("simulation failed");
            $finish;
        end
    end

    task automatic wait_idle();
        while (box_backlog.size() != 0 || in_valid || want_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // push the queued register writes back to back; only called while idle
    task automatic write_regs();
        while (reg_idx_q.size() != 0)
        begin
            cfg_index <= reg_idx_q.pop_front();
            cfg_data  <= reg_val_q.pop_front();
            cfg_valid <= 1'b1;
            do
                @(posedge clk);
            while (!(cfg_valid && cfg_ready));
            if (cfg_index < PLANE_REGS)
                frustum[cfg_index] = plane_t'(cfg_data);
            n_reg_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_reg(int idx, logic [63:0] val);
        reg_idx_q.push_back(CFG_IDX_W'(idx));
        reg_val_q.push_back(val);
    endtask

    initial
    begin
        plane_t p;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset planes are zero and never cull
        box_backlog.push_back(box_of(1'b0, -32768, -32768, -32768, 32767, 32767, 32767));
        box_backlog.push_back(box_of(1'b1, 32767, -32768, 0, 0, 0, 0));
        wait_idle();

        // axis-aligned cube |x|,|y|,|z| <= 1000
        queue_reg(0, {16'sd1000, 16'sd0, 16'sd0, 16'sd16384});
        queue_reg(1, {16'sd1000, 16'sd0, 16'sd0, -16'sd16384});
        queue_reg(2, {16'sd1000, 16'sd0, 16'sd16384, 16'sd0});
        queue_reg(3, {16'sd1000, 16'sd0, -16'sd16384, 16'sd0});
        queue_reg(4, {16'sd1000, 16'sd16384, 16'sd0, 16'sd0});
        queue_reg(5, {16'sd1000, -16'sd16384, 16'sd0, 16'sd0});
        write_regs();
        box_backlog.push_back(box_of(1'b0, -10, -10, -10, 10, 10, 10));
        box_backlog.push_back(box_of(1'b0, -2000, -5, -5, 0, 5, 5));
        box_backlog.push_back(box_of(1'b0, 2000, 0, 0, 3000, 10, 10));
        box_backlog.push_back(box_of(1'b0, 1000, 1000, 1000, 1000, 1000, 1000));
        box_backlog.push_back(box_of(1'b0, 500, 500, 500, -500, -500, -500));
        box_backlog.push_back(box_of(1'b0, 1500, 0, 0, -1500, 0, 0));
        box_backlog.push_back(box_of(1'b0, -32768, -32768, -32768, 32767, 32767, 32767));
        box_backlog.push_back(box_of(1'b1, 0, 0, 0, 32767, -32768, 32767));
        box_backlog.push_back(box_of(1'b1, 1001, 0, 0, 0, 0, 0));
        box_backlog.push_back(box_of(1'b1, 1000, -1000, 1000, -32768, 32767, -1));
        box_backlog.push_back(box_of(1'b1, -32768, -32768, -32768, 0, 0, 0));
        wait_idle();

        // extreme register contents; indexes past the last plane are dropped
        queue_reg(0, 64'h7FFF_8000_8000_8000);
        queue_reg(1, 64'h8000_7FFF_7FFF_7FFF);
        queue_reg(2, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_reg(3, 64'h0);
        queue_reg(4, 64'h0);
        queue_reg(5, 64'h0);
        queue_reg(6, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_reg(7, 64'h5555_5555_5555_5555);
        write_regs();
        box_backlog.push_back(box_of(1'b0, -32768, -32768, -32768, 32767, 32767, 32767));
        box_backlog.push_back(box_of(1'b0, 32767, 32767, 32767, -32768, -32768, -32768));
        box_backlog.push_back(box_of(1'b0, 0, 0, 0, 0, 0, 0));
        box_backlog.push_back(box_of(1'b0, -16384, -16384, -16384, -1, -1, -1));
        box_backlog.push_back(box_of(1'b1, -32768, -32768, -32768, 32767, 32767, 32767));
        box_backlog.push_back(box_of(1'b1, 32767, 32767, 32767, -32768, -32768, -32768));
        box_backlog.push_back(box_of(1'b1, -6000, -6000, -4384, 0, 0, 0));
        wait_idle();

        for (int k = 0; k < RAND_PHASES; k++)
        begin
            for (int i = 0; i < PLANE_REGS; i++)
            begin
                p = sane_plane();
                if (k == 2 && $urandom_range(0, 1) == 0)
                    p = plane_t'({$urandom, $urandom});
                else if (k == 4 && $urandom_range(0, 2) == 0)
                    p = '0;
                queue_reg(i, p);
            end
            write_regs();
            idle_en = (k < RAND_PHASES - 1);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                box_backlog.push_back(random_box());
            // sender holds off until every verdict of the phase is back
            wait_idle();
        end

        if (want_verdicts.size() != 0)
        begin
            $display("%t: %0d verdicts never arrived", $time, want_verdicts.size());
        end
        $display("checked %0d verdicts: %0d outside, %0d intersecting, %0d inside",
                 n_checked, n_by_verdict[0], n_by_verdict[1], n_by_verdict[2]);
        $display("%0d of them point tests, %0d plane register writes, %0d mismatches",
                 n_points, n_reg_writes, n_errors);
        if (n_errors == 0 && want_verdicts.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
hdl/fbc_pkg.sv
hdl/fbc_plane_mult.sv
hdl/fbc_plane_sum.sv
hdl/frustum_box_cull_core.sv
sim/frustum_box_cull_core_tb.sv
